// ----- hdl/srd_pkg.sv -----
`default_nettype none

package srd_pkg;

    localparam int OFFSET_WIDTH = 32;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] KIND_DATA = 3'd0;
    localparam logic [2:0] KIND_OK   = 3'd1;
    localparam logic [2:0] KIND_CSUM = 3'd2;
    localparam logic [2:0] KIND_FMT  = 3'd3;
    localparam logic [2:0] KIND_END  = 3'd4;

    localparam logic [0:0] CFG_STRICT     = 1'd0;
    localparam logic [0:0] CFG_COUNT_ONLY = 1'd1;

    localparam logic [7:0] CHAR_S  = 8'h53;
    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;
    localparam logic [7:0] SUM_OK  = 8'hff;

    typedef struct packed {
        logic       mode;
        logic [7:0] character;
    } in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [31:0] address;
        logic [3:0]  record_type;
        logic [7:0]  payload_length;
        logic [31:0] stream_offset;
    } out_t;

    // classified character handed from front to back
    typedef struct packed {
        logic       rewind;
        logic       is_s;
        logic       is_cr;
        logic       is_lf;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       digit_ok;
        logic [3:0] digit;
        logic [2:0] addr_len;   // zero for an invalid record type
    } token_t;

endpackage

`default_nettype wire

// ----- hdl/srd_front.sv -----
`default_nettype none

module srd_front
    import srd_pkg::*;
(
    input  wire logic   in_valid,
    output logic        in_stall,
    input  wire in_t    in_data,
    input  wire logic   queue_full,
    output logic        push,
    output token_t      token
);

    logic [7:0] c;

    assign c        = in_data.character;
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        token          = '0;
        token.rewind   = in_data.mode;
        token.is_s     = (c == CHAR_S);
        token.is_cr    = (c == CHAR_CR);
        token.is_lf    = (c == CHAR_LF);
        token.digit_ok = (c >= 8'h30) && (c <= 8'h39);
        token.digit    = token.digit_ok ? 4'(c - 8'h30) : 4'd0;
        if (token.digit_ok)
        begin
            token.hex_ok  = 1'b1;
            token.hex_val = 4'(c - 8'h30);
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            token.hex_ok  = 1'b1;
            token.hex_val = 4'(c - 8'h37);
        end
        else if ((c >= 8'h61) && (c <= 8'h66))
        begin
            token.hex_ok  = 1'b1;
            token.hex_val = 4'(c - 8'h57);
        end
        unique case (c)
            8'h30, 8'h31, 8'h35, 8'h39: token.addr_len = 3'd2;
            8'h32, 8'h38:               token.addr_len = 3'd3;
            8'h33, 8'h37:               token.addr_len = 3'd4;
            default:                    token.addr_len = 3'd0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/srd_queue.sv -----
`default_nettype none

module srd_queue
    import srd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire token_t push_data,
    input  wire logic   pop,
    output logic        full,
    output logic        empty,
    output token_t      head
);

    token_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic                  do_pop;

    assign full   = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign head   = slot_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/srd_back.sv -----
`default_nettype none

module srd_back
    import srd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   strict_checksum,
    input  wire logic   count_only,
    input  wire logic   queue_empty,
    input  wire token_t tok,
    output logic        pop,
    output logic        out_valid,
    input  wire logic   out_stall,
    output out_t        out_data
);

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LEN,
        PH_ADDR,
        PH_DATA,
        PH_SUM,
        PH_END,
        PH_ENDLF,
        PH_SKIP
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [3:0]               type_reg, type_next;
    logic [3:0]               high_reg, high_next;
    logic                     pend_reg, pend_next;
    logic [7:0]               left_reg, left_next;
    logic [2:0]               alen_reg, alen_next;
    logic [31:0]              addr_reg, addr_next;
    logic [7:0]               sum_reg, sum_next;
    logic [7:0]               idx_reg, idx_next;
    logic [OFFSET_WIDTH-1:0]  total_reg, total_next;
    logic                     stopped_reg, stopped_next;
    logic                     out_valid_reg;
    out_t                     out_data_reg;

    logic                     res_valid;
    out_t                     res;
    logic [7:0]               byte_val;
    logic                     data_type;
    logic [31:0]              total_out;

    assign pop       = !queue_empty && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign byte_val  = {high_reg, tok.hex_val};
    assign data_type = (type_reg >= 4'd1) && (type_reg <= 4'd3);
    assign total_out = 32'(total_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        type_next    = type_reg;
        high_next    = high_reg;
        pend_next    = pend_reg;
        left_next    = left_reg;
        alen_next    = alen_reg;
        addr_next    = addr_reg;
        sum_next     = sum_reg;
        idx_next     = idx_reg;
        total_next   = total_reg;
        stopped_next = stopped_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (tok.rewind)
        begin
            phase_next   = PH_HUNT;
            type_next    = '0;
            high_next    = '0;
            pend_next    = 1'b0;
            left_next    = '0;
            alen_next    = '0;
            addr_next    = '0;
            sum_next     = '0;
            idx_next     = '0;
            total_next   = '0;
            stopped_next = 1'b0;
        end
        else if (!stopped_reg)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (!tok.is_s)
                    begin
                        stopped_next      = 1'b1;
                        res_valid         = 1'b1;
                        res.kind          = KIND_END;
                        res.stream_offset = total_out;
                    end
                    else
                    begin
                        addr_next  = '0;
                        sum_next   = '0;
                        idx_next   = '0;
                        type_next  = '0;
                        pend_next  = 1'b0;
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_next = tok.digit;
                    if (tok.addr_len == 3'd0)
                    begin
                        phase_next        = PH_SKIP;
                        pend_next         = 1'b0;
                        res_valid         = 1'b1;
                        res.kind          = KIND_FMT;
                        res.address       = addr_reg;
                        res.record_type   = tok.digit;
                        res.stream_offset = total_out;
                    end
                    else
                    begin
                        alen_next  = tok.addr_len;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN, PH_ADDR, PH_DATA, PH_SUM:
                begin
                    if (!tok.hex_ok)
                    begin
                        phase_next        = PH_SKIP;
                        pend_next         = 1'b0;
                        res_valid         = 1'b1;
                        res.kind          = KIND_FMT;
                        res.address       = addr_reg;
                        res.record_type   = type_reg;
                        res.stream_offset = total_out;
                    end
                    else if (!pend_reg)
                    begin
                        high_next = tok.hex_val;
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        sum_next  = sum_reg + byte_val;
                        priority case (phase_reg)
                            PH_LEN:
                            begin
                                if (byte_val < ({5'd0, alen_reg} + 8'd1))
                                begin
                                    phase_next        = PH_SKIP;
                                    res_valid         = 1'b1;
                                    res.kind          = KIND_FMT;
                                    res.address       = addr_reg;
                                    res.record_type   = type_reg;
                                    res.stream_offset = total_out;
                                end
                                else
                                begin
                                    left_next  = byte_val - {5'd0, alen_reg} - 8'd1;
                                    phase_next = PH_ADDR;
                                end
                            end
                            PH_ADDR:
                            begin
                                addr_next = {addr_reg[23:0], byte_val};
                                alen_next = alen_reg - 3'd1;
                                if (alen_reg == 3'd1)
                                begin
                                    phase_next = (left_reg == 8'd0) ? PH_SUM : PH_DATA;
                                end
                            end
                            PH_DATA:
                            begin
                                if (data_type)
                                begin
                                    if (!count_only)
                                    begin
                                        res_valid         = 1'b1;
                                        res.kind          = KIND_DATA;
                                        res.data_byte     = byte_val;
                                        res.address       = addr_reg + {24'd0, idx_reg};
                                        res.record_type   = type_reg;
                                        res.stream_offset = total_out;
                                    end
                                    total_next = total_reg + 1'b1;
                                end
                                idx_next  = idx_reg + 8'd1;
                                left_next = left_reg - 8'd1;
                                if (left_reg == 8'd1)
                                begin
                                    phase_next = PH_SUM;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_END;
                            end
                        endcase
                    end
                end
                PH_END, PH_ENDLF:
                begin
                    if ((phase_reg == PH_END) && tok.is_cr)
                    begin
                        phase_next = PH_ENDLF;
                    end
                    else
                    begin
                        phase_next        = PH_HUNT;
                        res_valid         = 1'b1;
                        res.kind          = (!count_only && (sum_reg != SUM_OK))
                                            ? KIND_CSUM : KIND_OK;
                        res.address       = addr_reg;
                        res.record_type   = type_reg;
                        res.payload_length = data_type ? idx_reg : 8'd0;
                        res.stream_offset = total_out;
                        if ((res.kind == KIND_CSUM) && strict_checksum)
                        begin
                            stopped_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (tok.is_lf)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            type_reg      <= '0;
            high_reg      <= '0;
            pend_reg      <= 1'b0;
            left_reg      <= '0;
            alen_reg      <= '0;
            addr_reg      <= '0;
            sum_reg       <= '0;
            idx_reg       <= '0;
            total_reg     <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            phase_reg     <= phase_next;
            type_reg      <= type_next;
            high_reg      <= high_next;
            pend_reg      <= pend_next;
            left_reg      <= left_next;
            alen_reg      <= alen_next;
            addr_reg      <= addr_next;
            sum_reg       <= sum_next;
            idx_reg       <= idx_next;
            total_reg     <= total_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= res_valid;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/srecord_stream_decoder_top.sv -----
`default_nettype none

// S-record decoder: one ASCII character beat per cycle while the queue has
// room. A front stage classifies each character and writes it to a
// four-entry queue; the record FSM behind it retires one queued character per
// cycle, unless the output stalls a held result, into a result register, which
// takes each result at the edge that pops its character. The input stalls only
// while the queue is full, i.e. when the output side has held off. A beat
// with mode set rewinds the stream.

module srecord_stream_decoder_top
    import srd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_t         in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_t             out_data,
    input  wire logic        cfg_write_en,
    input  wire logic [0:0]  cfg_index,
    input  wire logic        cfg_data
);

    logic   strict_reg;
    logic   count_only_reg;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    token_t push_tok;
    token_t head_tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg     <= 1'b0;
            count_only_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_STRICT:     strict_reg     <= cfg_data;
                CFG_COUNT_ONLY: count_only_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    srd_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .queue_full (full),
        .push       (push),
        .token      (push_tok)
    );

    srd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_tok),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .head      (head_tok)
    );

    srd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .strict_checksum (strict_reg),
        .count_only      (count_only_reg),
        .queue_empty     (empty),
        .tok             (head_tok),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data)
    );

endmodule

`default_nettype wire

// ----- sim/tb_srecord_stream_decoder_top.sv -----
`timescale 1ns / 1ps

module tb_srecord_stream_decoder_top;

    import srd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 60;
    localparam int SEGMENTS      = 6;
    localparam int SEG_ITEMS     = 130;
    localparam logic [5:0] STRICT_PLAN = 6'b011010;
    localparam logic [5:0] COUNT_PLAN  = 6'b001100;
    localparam logic [63:0] RECORD_TYPES = "12305789";

    typedef enum logic [3:0] {
        ST_HUNT, ST_TYPE, ST_LEN, ST_ADDR, ST_DATA, ST_SUM, ST_END, ST_ENDLF, ST_SKIP
    } parse_state_t;

    typedef struct packed {
        in_t  beat;
        logic typed;
        out_t want;
    } script_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        cfg_write_en = 1'b0;
    logic [0:0]  cfg_index = CFG_STRICT;
    logic        cfg_data = 1'b0;

    // decoder model state
    parse_state_t            dec_st;
    logic [3:0]              dec_type;
    logic [3:0]              dec_high;
    logic                    dec_pend;
    logic [7:0]              dec_left;
    logic [2:0]              dec_addr_left;
    logic [31:0]             dec_addr;
    logic [7:0]              dec_sum;
    logic [7:0]              dec_index;
    logic [OFFSET_WIDTH-1:0] dec_offset;
    logic                    dec_stopped;
    logic                    cfg_strict = 1'b0;
    logic                    cfg_count_only = 1'b0;

    out_t         decoded_due[$];
    in_t          line_q[$];
    script_row_t  script[$];
    int           error_count = 0;
    int unsigned  cycle_count = 0;
    int           send_idle = 0;
    int           recv_idle = 0;
    int           hold_req = 0;
    int           hold_left = 0;

    srecord_stream_decoder_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic in_t beat_of(input logic mode, input logic [7:0] ch);
        in_t b;
        b.mode = mode;
        b.character = ch;
        return b;
    endfunction

    function automatic out_t result_of(input logic [2:0] kind, input logic [7:0] data,
                                       input logic [31:0] addr, input logic [3:0] rtype,
                                       input logic [7:0] plen, input logic [31:0] ofs);
        out_t r;
        r.kind = kind;
        r.data_byte = data;
        r.address = addr;
        r.record_type = rtype;
        r.payload_length = plen;
        r.stream_offset = ofs;
        return r;
    endfunction

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 10;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return "0" + n;
        return (($urandom_range(1) != 0) ? "a" : "A") + n - 8'd10;
    endfunction

    function automatic logic [7:0] rand_char();
        return 8'($urandom_range(255));
    endfunction

    function automatic void clear_decoder();
        dec_st = ST_HUNT;
        dec_type = '0;
        dec_high = '0;
        dec_pend = 1'b0;
        dec_left = '0;
        dec_addr_left = '0;
        dec_addr = '0;
        dec_sum = '0;
        dec_index = '0;
        dec_offset = '0;
        dec_stopped = 1'b0;
    endfunction

    function automatic out_t format_fault();
        out_t r;
        r = '0;
        dec_st = ST_SKIP;
        dec_pend = 1'b0;
        r.kind = KIND_FMT;
        r.address = dec_addr;
        r.record_type = dec_type;
        r.stream_offset = dec_offset;
        return r;
    endfunction

    task automatic decode_char(input in_t beat, output logic hit, output out_t r);
        logic [7:0] c;
        logic [7:0] b;
        logic       is_data;
        int         v;
        c = beat.character;
        hit = 1'b0;
        r = '0;
        is_data = (dec_type >= 4'd1 && dec_type <= 4'd3);
        if (beat.mode)
        begin
            clear_decoder();
            return;
        end
        if (dec_stopped)
            return;
        case (dec_st)
            ST_HUNT:
                if (c != CHAR_S)
                begin
                    dec_stopped = 1'b1;
                    hit = 1'b1;
                    r.kind = KIND_END;
                    r.stream_offset = dec_offset;
                end
                else
                begin
                    dec_addr = '0;
                    dec_sum = '0;
                    dec_index = '0;
                    dec_type = '0;
                    dec_pend = 1'b0;
                    dec_st = ST_TYPE;
                end
            ST_TYPE:
            begin
                dec_type = (c >= "0" && c <= "9") ? c[3:0] : 4'd0;
                case (c)
                    "0", "1", "5", "9": dec_addr_left = 3'd2;
                    "2", "8":           dec_addr_left = 3'd3;
                    "3", "7":           dec_addr_left = 3'd4;
                    default:            dec_addr_left = 3'd0;
                endcase
                if (dec_addr_left == 3'd0)
                begin
                    hit = 1'b1;
                    r = format_fault();
                end
                else
                    dec_st = ST_LEN;
            end
            ST_LEN, ST_ADDR, ST_DATA, ST_SUM:
            begin
                v = nibble_of(c);
                if (v < 0)
                begin
                    hit = 1'b1;
                    r = format_fault();
                end
                else if (!dec_pend)
                begin
                    dec_high = v[3:0];
                    dec_pend = 1'b1;
                end
                else
                begin
                    dec_pend = 1'b0;
                    b = {dec_high, v[3:0]};
                    dec_sum = dec_sum + b;
                    case (dec_st)
                        ST_LEN:
                            if (b < 8'd1 + dec_addr_left)
                            begin
                                hit = 1'b1;
                                r = format_fault();
                            end
                            else
                            begin
                                dec_left = b - 8'd1 - dec_addr_left;
                                dec_st = ST_ADDR;
                            end
                        ST_ADDR:
                        begin
                            dec_addr = {dec_addr[23:0], b};
                            dec_addr_left = dec_addr_left - 3'd1;
                            if (dec_addr_left == 3'd0)
                                dec_st = (dec_left == 8'd0) ? ST_SUM : ST_DATA;
                        end
                        ST_DATA:
                        begin
                            if (is_data)
                            begin
                                if (!cfg_count_only)
                                begin
                                    hit = 1'b1;
                                    r.kind = KIND_DATA;
                                    r.data_byte = b;
                                    r.address = dec_addr + dec_index;
                                    r.record_type = dec_type;
                                    r.stream_offset = dec_offset;
                                end
                                dec_offset = dec_offset + 1'b1;
                            end
                            dec_index = dec_index + 8'd1;
                            dec_left = dec_left - 8'd1;
                            if (dec_left == 8'd0)
                                dec_st = ST_SUM;
                        end
                        default:
                            dec_st = ST_END;
                    endcase
                end
            end
            ST_END, ST_ENDLF:
                if (dec_st == ST_END && c == CHAR_CR)
                    dec_st = ST_ENDLF;
                else
                begin
                    hit = 1'b1;
                    r.kind = (!cfg_count_only && dec_sum != SUM_OK) ? KIND_CSUM : KIND_OK;
                    r.address = dec_addr;
                    r.record_type = dec_type;
                    r.payload_length = is_data ? dec_index : 8'd0;
                    r.stream_offset = dec_offset;
                    dec_st = ST_HUNT;
                    if (r.kind == KIND_CSUM && cfg_strict)
                        dec_stopped = 1'b1;
                end
            default:
                if (c == CHAR_LF)
                    dec_st = ST_HUNT;
        endcase
    endtask

    task automatic offer_char(input in_t beat, input logic typed, input out_t want);
        logic hit;
        out_t r;
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        do @(posedge clk); while (in_stall);
        decode_char(beat, hit, r);
        if (typed)
            decoded_due.push_back(want);
        else if (hit)
            decoded_due.push_back(r);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (decoded_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic strict_val, input logic count_val);
        cfg_write_en <= 1'b1;
        cfg_index <= CFG_STRICT;
        cfg_data <= strict_val;
        @(posedge clk);
        cfg_strict = strict_val;
        cfg_index <= CFG_COUNT_ONLY;
        cfg_data <= count_val;
        @(posedge clk);
        cfg_count_only = count_val;
        cfg_write_en <= 1'b0;
    endtask

    task automatic add_row(input logic mode, input logic [7:0] ch, input logic typed,
                           input out_t want);
        script_row_t row;
        row.beat = beat_of(mode, ch);
        row.typed = typed;
        row.want = want;
        script.push_back(row);
    endtask

    // one record into line_q; broken ones carry a bad type, a bad digit or a short count
    task automatic add_record(input logic broken);
        logic [7:0]  tch;
        logic [7:0]  cnt;
        logic [7:0]  cs;
        logic [7:0]  c;
        logic [7:0]  body[$];
        logic [31:0] adr;
        int          alen;
        int          nbytes;
        int          flaw;
        int          pos;
        int          r;
        int          i;
        r = ($urandom_range(99) < 75) ? $urandom_range(2) : $urandom_range(7, 3);
        tch = RECORD_TYPES[8*(7-r) +: 8];
        case (tch)
            "0", "1", "5", "9": alen = 2;
            "2", "8":           alen = 3;
            default:            alen = 4;
        endcase
        r = $urandom_range(99);
        nbytes = (r < 85) ? $urandom_range(6) : (r < 98) ? $urandom_range(40, 7) : 254 - alen;
        flaw = broken ? $urandom_range(2) : 3;
        cnt = (flaw == 2) ? 8'($urandom_range(alen)) : 8'(alen + nbytes + 1);
        r = $urandom_range(19);
        adr = (r == 0) ? 32'h0 : (r < 3) ? 32'hffff_ffff : $urandom;
        body.push_back(cnt);
        for (i = alen - 1; i >= 0; i--)
            body.push_back(adr[8*i +: 8]);
        repeat (nbytes) body.push_back(rand_char());
        cs = 8'hff;
        foreach (body[k])
            cs = cs - body[k];
        if ($urandom_range(99) < 12)
            cs = cs ^ 8'($urandom_range(255, 1));
        body.push_back(cs);
        line_q.push_back(beat_of(1'b0, CHAR_S));
        line_q.push_back(beat_of(1'b0, tch));
        foreach (body[k])
        begin
            line_q.push_back(beat_of(1'b0, hex_char(body[k][7:4])));
            line_q.push_back(beat_of(1'b0, hex_char(body[k][3:0])));
        end
        if (flaw == 0)
        begin
            do c = rand_char();
            while ((c >= "0" && c <= "3") || c == "5" || (c >= "7" && c <= "9"));
            line_q[1] = beat_of(1'b0, c);
        end
        else if (flaw == 1)
        begin
            pos = $urandom_range(line_q.size() - 1, 2);
            do c = rand_char(); while (nibble_of(c) >= 0);
            line_q[pos] = beat_of(1'b0, c);
        end
        if (broken)
        begin
            repeat ($urandom_range(4)) line_q.push_back(beat_of(1'b0, rand_char()));
            line_q.push_back(beat_of(1'b0, CHAR_LF));
        end
        else
        begin
            r = $urandom_range(99);
            if (r < 55 || (r >= 80 && r < 90))
                line_q.push_back(beat_of(1'b0, CHAR_CR));
            if (r < 80)
                line_q.push_back(beat_of(1'b0, CHAR_LF));
            else
            begin
                do c = rand_char(); while (r >= 90 && c == CHAR_CR);
                line_q.push_back(beat_of(1'b0, c));
            end
        end
    endtask

    task automatic run_random(input int budget);
        int used;
        int pick;
        used = 0;
        while (used < budget)
        begin
            line_q.delete();
            pick = $urandom_range(99);
            if (dec_stopped && $urandom_range(99) < 85)
            begin
                line_q.push_back(beat_of(1'b1, rand_char()));
                used++;
            end
            else if (pick < 72)
            begin
                add_record(1'b0);
                used += line_q.size();
            end
            else if (pick < 86)
            begin
                add_record(1'b1);
                used += line_q.size();
            end
            else if (pick < 93)
            begin
                // end of data, then beats that are ignored
                line_q.push_back(beat_of(1'b0, rand_char()));
                repeat ($urandom_range(3)) line_q.push_back(beat_of(1'b0, rand_char()));
                used += line_q.size();
            end
            else
            begin
                line_q.push_back(beat_of(1'b1, rand_char()));
                used++;
            end
            foreach (line_q[k])
                offer_char(line_q[k], 1'b0, '0);
        end
    endtask

    task automatic check_result(input out_t got);
        out_t want;
        if (decoded_due.size() == 0)
        begin
            if (error_count < 10)
                $display("unexpected result: kind=%0d byte=%02h addr=%08h type=%0d len=%0d ofs=%0d",
                         got.kind, got.data_byte, got.address, got.record_type,
                         got.payload_length, got.stream_offset);
            error_count++;
        end
        else
        begin
            want = decoded_due.pop_front();
            if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                got.address !== want.address || got.record_type !== want.record_type ||
                got.payload_length !== want.payload_length ||
                got.stream_offset !== want.stream_offset)
            begin
                if (error_count < 10)
                begin
                    $display("mismatch exp: kind=%0d byte=%02h addr=%08h type=%0d len=%0d ofs=%0d",
                             want.kind, want.data_byte, want.address, want.record_type,
                             want.payload_length, want.stream_offset);
                    $display("         got: kind=%0d byte=%02h addr=%08h type=%0d len=%0d ofs=%0d",
                             got.kind, got.data_byte, got.address, got.record_type,
                             got.payload_length, got.stream_offset);
                end
                error_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result(out_data);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    initial
    begin
        clear_decoder();

        add_row(1'b0, CHAR_S,  1'b0, '0);
        add_row(1'b0, "1",     1'b0, '0);
        add_row(1'b0, "0",     1'b0, '0);
        add_row(1'b0, "4",     1'b0, '0);
        add_row(1'b0, "F",     1'b0, '0);
        add_row(1'b0, "F",     1'b0, '0);
        add_row(1'b0, "F",     1'b0, '0);
        add_row(1'b0, "F",     1'b0, '0);
        add_row(1'b0, "a",     1'b0, '0);
        add_row(1'b0, "b",     1'b1, result_of(KIND_DATA, 8'hab, 32'hffff, 4'd1, 8'd0, 32'd0));
        add_row(1'b0, "5",     1'b0, '0);
        add_row(1'b0, "2",     1'b0, '0);
        add_row(1'b0, CHAR_CR, 1'b0, '0);
        add_row(1'b0, CHAR_LF, 1'b1, result_of(KIND_OK, 8'h00, 32'hffff, 4'd1, 8'd1, 32'd1));
        add_row(1'b0, CHAR_S,  1'b0, '0);
        add_row(1'b0, "4",     1'b1, result_of(KIND_FMT, 8'h00, 32'h0, 4'd4, 8'd0, 32'd1));
        add_row(1'b0, CHAR_LF, 1'b0, '0);
        add_row(1'b0, 8'hff,   1'b1, result_of(KIND_END, 8'h00, 32'h0, 4'd0, 8'd0, 32'd1));
        add_row(1'b0, CHAR_S,  1'b0, '0);
        add_row(1'b1, 8'h00,   1'b0, '0);
        add_row(1'b0, CHAR_S,  1'b0, '0);
        add_row(1'b0, "9",     1'b0, '0);
        add_row(1'b0, "0",     1'b0, '0);
        add_row(1'b0, "2",     1'b1, result_of(KIND_FMT, 8'h00, 32'h0, 4'd9, 8'd0, 32'd0));
        add_row(1'b0, CHAR_LF, 1'b0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 17;
        recv_idle = 79;
        foreach (script[i])
            offer_char(script[i].beat, script[i].typed, script[i].want);
        settle();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 2)
                0:       begin send_idle = 17; recv_idle = 79; end
                1:       begin send_idle = 79; recv_idle = 17; end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase
            write_regs(STRICT_PLAN[seg], COUNT_PLAN[seg]);
            // output held off while beats keep coming, so the input backs up
            hold_req = HOLD_CYCLES;
            offer_char(beat_of(1'b1, rand_char()), 1'b0, '0);
            run_random(SEG_ITEMS);
            settle();
        end

        if (error_count == 0 && decoded_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/srd_pkg.sv
hdl/srd_front.sv
hdl/srd_queue.sv
hdl/srd_back.sv
hdl/srecord_stream_decoder_top.sv
sim/tb_srecord_stream_decoder_top.sv
